// ===== design/spi_bts_pkg.sv =====
// Package for the SPI block transfer sequencer.
// Holds the item types, status and request codes, and the word layout constants.
// Depends on nothing; every module file of the block imports it.
package spi_bts_pkg;

  localparam int LenBits = 16;

  localparam int PAddrW = 3;
  localparam logic RegIntLevel = 1'b0;

  localparam logic [9:0] FlagMask = 10'h35F;
  localparam int RxFullFlagBit = 8;

  typedef logic [LenBits-1:0] len_t;

  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StPending = 2'd1,
    StDone    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ReqStart   = 2'd0,
    ReqTxEmpty = 2'd1,
    ReqRxFull  = 2'd2,
    ReqOther   = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] block_len;
    logic        has_source;
    logic        has_dest;
    logic [1:0]  frame_format;
    logic [7:0]  chip_sel;
    logic        wdelay_en;
    logic        cs_hold_en;
    logic [7:0]  src_byte;
    logic [7:0]  rx_byte_in;
    logic [15:0] flag_bits;
  } in_item_t;

  typedef struct packed {
    logic [28:0] dat1_word;
    logic        dat1_valid;
    logic [7:0]  rx_byte;
    logic        rx_store;
    logic        dummy_read;
    logic [1:0]  tx_state;
    logic [1:0]  rx_state;
    logic        end_notify;
    logic [9:0]  flag_clear;
    logic [7:0]  notify_code;
  } out_item_t;

  typedef struct packed {
    logic       cs_hold;
    logic       wdelay;
    logic [7:0] chip_sel;
    logic [1:0] fmt;
  } frame_t;

endpackage

// ===== design/spi_bts_in_if.sv =====
// Input channel of the SPI block transfer sequencer: valid, ready and the event fields.
// Depends on nothing else.
interface spi_bts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] block_len;
  logic        has_source;
  logic        has_dest;
  logic [1:0]  frame_format;
  logic [7:0]  chip_sel;
  logic        wdelay_en;
  logic        cs_hold_en;
  logic [7:0]  src_byte;
  logic [7:0]  rx_byte_in;
  logic [15:0] flag_bits;

  modport source (
    output valid, req_type, block_len, has_source, has_dest, frame_format, chip_sel,
           wdelay_en, cs_hold_en, src_byte, rx_byte_in, flag_bits,
    input  ready
  );

  modport sink (
    input  valid, req_type, block_len, has_source, has_dest, frame_format, chip_sel,
           wdelay_en, cs_hold_en, src_byte, rx_byte_in, flag_bits,
    output ready
  );
endinterface

// ===== design/spi_bts_out_if.sv =====
// Output channel of the SPI block transfer sequencer: valid, ready and the result fields.
// Depends on nothing else.
interface spi_bts_out_if;
  logic        valid;
  logic        ready;
  logic [28:0] dat1_word;
  logic        dat1_valid;
  logic [7:0]  rx_byte;
  logic        rx_store;
  logic        dummy_read;
  logic [1:0]  tx_state;
  logic [1:0]  rx_state;
  logic        end_notify;
  logic [9:0]  flag_clear;
  logic [7:0]  notify_code;

  modport source (
    output valid, dat1_word, dat1_valid, rx_byte, rx_store, dummy_read, tx_state,
           rx_state, end_notify, flag_clear, notify_code,
    input  ready
  );

  modport sink (
    input  valid, dat1_word, dat1_valid, rx_byte, rx_store, dummy_read, tx_state,
           rx_state, end_notify, flag_clear, notify_code,
    output ready
  );
endinterface

// ===== design/spi_block_transfer_sequencer.sv =====
// SPI block transfer sequencer for one byte-wide channel.
// Each event item (start, transmit empty, receive full, other) yields one result item.
// The input channel carries the event and its fields; the output channel carries the
// transmit data word, the received byte, status and flag reports.
// The interrupt level register sits at byte address 0 of the APB-style port and may
// only be written while no item is in flight.
// An item accepted into the input register is evaluated against the transfer state
// and lands in the result register once that register can take it; its result is then
// offered on the output channel.
// One item is accepted every cycle while the receiver does not stall; the rate is set
// by the single evaluation stage between the input and result registers.
// When the receiver stalls, the result register holds its item and the input register
// keeps accepting until it too is full; then ready drops until the result is taken.
// Reset clears both statuses to idle, the byte counts, the interrupt level and both
// stage valid bits; no clearing pass is needed.
// Depends on spi_bts_pkg, spi_bts_in_if, spi_bts_out_if and the spi_bts_* modules.
module spi_block_transfer_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spi_bts_in_if.sink                     in_i,
  spi_bts_out_if.source                  out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spi_bts_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import spi_bts_pkg::*;

  logic        s1_valid;
  in_item_t    s1_item;
  out_item_t   res;
  logic        can_take;
  logic        fire;
  logic [15:0] int_level;

  assign fire = s1_valid && can_take;

  spi_bts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .int_level_o (int_level)
  );

  spi_bts_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (can_take),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  spi_bts_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (s1_item),
    .int_level_i (int_level[9:0]),
    .res_o       (res)
  );

  spi_bts_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid),
    .res_i        (res),
    .can_take_o   (can_take),
    .out_o        (out_o)
  );
endmodule

// ===== design/spi_bts_cfg.sv =====
// APB-style configuration register file holding the interrupt level register.
// Depends on spi_bts_pkg.
module spi_bts_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spi_bts_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [15:0]                int_level_o
);
  import spi_bts_pkg::*;

  logic [15:0] int_level_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegIntLevel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_level_q <= '0;
    end else if (wr_en) begin
      int_level_q <= pwdata[15:0];
    end
  end

  assign prdata      = (paddr[2] == RegIntLevel) ? {16'h0000, int_level_q} : 32'h0;
  assign int_level_o = int_level_q;
endmodule

// ===== design/spi_bts_in_stage.sv =====
// Input register of the SPI block transfer sequencer.
// Captures one event item per cycle unless the result register stalls it; depends on spi_bts_pkg and spi_bts_in_if.
module spi_bts_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spi_bts_in_if.sink            in_i,
  input  logic                  advance_i,
  output logic                  valid_o,
  output spi_bts_pkg::in_item_t item_o
);
  import spi_bts_pkg::*;

  logic     valid_q;
  in_item_t item_q;
  in_item_t item_d;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  assign item_d = '{
    req_type:     in_i.req_type,
    block_len:    in_i.block_len,
    has_source:   in_i.has_source,
    has_dest:     in_i.has_dest,
    frame_format: in_i.frame_format,
    chip_sel:     in_i.chip_sel,
    wdelay_en:    in_i.wdelay_en,
    cs_hold_en:   in_i.cs_hold_en,
    src_byte:     in_i.src_byte,
    rx_byte_in:   in_i.rx_byte_in,
    flag_bits:    in_i.flag_bits
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== design/spi_bts_engine.sv =====
// Transfer state and per-event result logic of the SPI block transfer sequencer.
// Depends on spi_bts_pkg.
module spi_bts_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  spi_bts_pkg::in_item_t  item_i,
  input  logic [9:0]             int_level_i,
  output spi_bts_pkg::out_item_t res_o
);
  import spi_bts_pkg::*;

  status_e   tx_st_q, tx_st_d;
  status_e   rx_st_q, rx_st_d;
  len_t      tx_rem_q, tx_rem_d;
  len_t      rx_rem_q, rx_rem_d;
  logic      src_q, src_d;
  logic      dst_q, dst_d;
  frame_t    frame_q, frame_d;
  len_t      len_sat;
  len_t      tx_rem_dec;
  len_t      rx_rem_dec;
  logic [31:0] blk_wide;
  logic [9:0]  flags_masked;
  logic [7:0]  tx_byte;
  logic        hold;
  out_item_t   res;

  assign blk_wide     = 32'(item_i.block_len);
  assign len_sat      = ((blk_wide >> LenBits) != 32'h0) ? '1 : LenBits'(blk_wide);
  assign tx_rem_dec   = tx_rem_q - len_t'(1);
  assign rx_rem_dec   = rx_rem_q - len_t'(1);
  assign flags_masked = item_i.flag_bits[9:0] & int_level_i & FlagMask;
  assign tx_byte      = src_q ? item_i.src_byte : 8'h00;
  assign hold         = (tx_rem_dec != '0) && frame_q.cs_hold;

  always_comb begin
    tx_st_d  = tx_st_q;
    rx_st_d  = rx_st_q;
    tx_rem_d = tx_rem_q;
    rx_rem_d = rx_rem_q;
    src_d    = src_q;
    dst_d    = dst_q;
    frame_d  = frame_q;
    res      = '0;
    unique case (req_e'(item_i.req_type))
      ReqStart: begin
        src_d    = item_i.has_source;
        dst_d    = item_i.has_dest;
        frame_d  = '{cs_hold: item_i.cs_hold_en, wdelay: item_i.wdelay_en,
                     chip_sel: item_i.chip_sel, fmt: item_i.frame_format};
        tx_rem_d = len_sat;
        rx_rem_d = len_sat;
        if (len_sat == '0) begin
          tx_st_d        = StDone;
          rx_st_d        = StDone;
          res.end_notify = 1'b1;
        end else begin
          tx_st_d = StPending;
          rx_st_d = StPending;
        end
      end
      ReqTxEmpty: begin
        if (tx_st_q == StPending) begin
          tx_rem_d       = tx_rem_dec;
          res.dat1_word  = {hold, 1'b0, frame_q.wdelay, frame_q.fmt, frame_q.chip_sel,
                            8'h00, tx_byte};
          res.dat1_valid = 1'b1;
          res.dummy_read = (rx_st_q != StPending) && item_i.flag_bits[RxFullFlagBit];
          if (tx_rem_dec == '0) begin
            tx_st_d = StDone;
          end
        end
      end
      ReqRxFull: begin
        if (rx_st_q == StPending) begin
          rx_rem_d     = rx_rem_dec;
          res.rx_byte  = item_i.rx_byte_in;
          res.rx_store = dst_q;
          if (rx_rem_dec == '0) begin
            rx_st_d        = StDone;
            res.end_notify = 1'b1;
          end
        end
      end
      ReqOther: begin
        res.flag_clear  = flags_masked;
        res.notify_code = flags_masked[7:0];
      end
      default: begin
      end
    endcase
    res.tx_state = tx_st_d;
    res.rx_state = rx_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_st_q  <= StIdle;
      rx_st_q  <= StIdle;
      tx_rem_q <= '0;
      rx_rem_q <= '0;
      src_q    <= 1'b0;
      dst_q    <= 1'b0;
      frame_q  <= '0;
    end else if (fire_i) begin
      tx_st_q  <= tx_st_d;
      rx_st_q  <= rx_st_d;
      tx_rem_q <= tx_rem_d;
      rx_rem_q <= rx_rem_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      frame_q  <= frame_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  a_tx_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_st_q == StPending) |-> (tx_rem_q != '0))
    else $error("transmit side pending with zero bytes left");

  a_rx_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_st_q == StPending) |-> (rx_rem_q != '0))
    else $error("receive side pending with zero bytes left");

  a_rx_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (item_i.req_type == ReqRxFull) && (rx_st_q == StPending)
      && (rx_rem_q == len_t'(1))) |=> (rx_st_q == StDone))
    else $error("receive side did not complete on its last byte");

  a_end_notify_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.end_notify |-> ((item_i.req_type == ReqStart) || (item_i.req_type == ReqRxFull)))
    else $error("end notification raised by a transmit or other event");
`endif
endmodule

// ===== design/spi_bts_out_stage.sv =====
// Result register of the SPI block transfer sequencer, driving the output channel.
// Depends on spi_bts_pkg and spi_bts_out_if.
module spi_bts_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_valid_i,
  input  spi_bts_pkg::out_item_t res_i,
  output logic                   can_take_o,
  spi_bts_out_if.source          out_o
);
  import spi_bts_pkg::*;

  logic      valid_q;
  out_item_t res_q;

  assign can_take_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && load_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.dat1_word   = res_q.dat1_word;
  assign out_o.dat1_valid  = res_q.dat1_valid;
  assign out_o.rx_byte     = res_q.rx_byte;
  assign out_o.rx_store    = res_q.rx_store;
  assign out_o.dummy_read  = res_q.dummy_read;
  assign out_o.tx_state    = res_q.tx_state;
  assign out_o.rx_state    = res_q.rx_state;
  assign out_o.end_notify  = res_q.end_notify;
  assign out_o.flag_clear  = res_q.flag_clear;
  assign out_o.notify_code = res_q.notify_code;
endmodule
